/* rtl/display_idle_dim_off_controller_assert.svh */
// assertion macros for the backlight sleep controller
`ifndef DISPLAY_IDLE_DIM_OFF_CONTROLLER_ASSERT_SVH
`define DISPLAY_IDLE_DIM_OFF_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, off while reset is held
`define DIDO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, off while reset is held
`define DIDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DIDO_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define DIDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/dido_pkg.sv */
package dido_pkg;

    // event kinds
    localparam logic [1:0] FUNC_TICK      = 2'd0;
    localparam logic [1:0] FUNC_KEY       = 2'd1;
    localparam logic [1:0] FUNC_SHIELD_PR = 2'd2;
    localparam logic [1:0] FUNC_SHIELD_RL = 2'd3;

    // sleep state codes
    localparam logic [1:0] SLEEP_AWAKE = 2'd0;
    localparam logic [1:0] SLEEP_DIM   = 2'd1;
    localparam logic [1:0] SLEEP_OFF   = 2'd2;

    // notice codes
    localparam logic [1:0] NOTICE_NONE  = 2'd0;
    localparam logic [1:0] NOTICE_ENTER = 2'd1;
    localparam logic [1:0] NOTICE_LEAVE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SLEEP_SECONDS  = 2'd0;
    localparam logic [1:0] REG_TICK_PERIOD_MS = 2'd1;
    localparam logic [1:0] REG_DIM_TO_OFF_MS  = 2'd2;
    localparam logic [1:0] REG_DIM_LEVEL      = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    // derived threshold widths
    localparam int SLEEP_MS_W = 27;
    localparam int OFF_MS_W   = 28;
    localparam int WAKE_MS_W  = 15;

    localparam logic [SLEEP_MS_W-1:0] MS_PER_SECOND    = 27'd1000;
    localparam logic [6:0]            MIN_SAVED_LEVEL  = 7'd5;
    localparam logic [6:0]            RESET_BRIGHTNESS = 7'd75;
    localparam logic [13:0]           RESET_TICK_MS    = 14'd300;
    localparam logic [21:0]           RESET_DIM_OFF_MS = 22'd60000;
    localparam logic [6:0]            RESET_DIM_LEVEL  = 7'd20;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic [31:0] touch_idle_ms;
        logic        gated;
        logic [6:0]  current_brightness;
    } t_event;

    typedef struct packed {
        logic       brightness_write;
        logic [6:0] brightness_level;
        logic [1:0] sleep_state;
        logic [1:0] dim_notice;
        logic [1:0] off_notice;
        logic       shield_shown;
        logic       key_consumed;
    } t_result;

    // classified event between front and back
    typedef struct packed {
        logic [1:0]            func;
        logic [31:0]           now_ms;
        logic                  gated;
        logic                  touch_wake;
        logic                  touch_sleep;
        logic                  touch_off;
        logic                  sleep_en;
        logic [6:0]            save_level;
        logic [6:0]            dim_level;
        logic [WAKE_MS_W-1:0]  wake_ms;
        logic [SLEEP_MS_W-1:0] sleep_ms;
        logic [OFF_MS_W-1:0]   off_ms;
    } t_cls;

endpackage

/* rtl/dido_front.sv */
module dido_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dido_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dido_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  dido_pkg::t_event               i_event,
    output dido_pkg::t_cls                 o_cls
);
    import dido_pkg::*;

    logic [SLEEP_MS_W-1:0] r_sleep_ms, n_sleep_ms;
    logic [OFF_MS_W-1:0]   r_off_ms, n_off_ms;
    logic [WAKE_MS_W-1:0]  r_wake_ms, n_wake_ms;
    logic [21:0]           r_dim_off, n_dim_off;
    logic [6:0]            r_dim_level, n_dim_level;
    logic [SLEEP_MS_W-1:0] wr_sleep_ms;

    // thresholds are kept in milliseconds, updated on each write
    assign wr_sleep_ms = SLEEP_MS_W'(i_cfg_wdata[16:0]) * MS_PER_SECOND;

    always_comb begin
        n_sleep_ms  = r_sleep_ms;
        n_off_ms    = r_off_ms;
        n_wake_ms   = r_wake_ms;
        n_dim_off   = r_dim_off;
        n_dim_level = r_dim_level;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SLEEP_SECONDS: begin
                    n_sleep_ms = wr_sleep_ms;
                    n_off_ms   = OFF_MS_W'(wr_sleep_ms) + OFF_MS_W'(r_dim_off);
                end
                REG_TICK_PERIOD_MS: begin
                    n_wake_ms = {i_cfg_wdata[13:0], 1'b0};
                end
                REG_DIM_TO_OFF_MS: begin
                    n_dim_off = i_cfg_wdata[21:0];
                    n_off_ms  = OFF_MS_W'(r_sleep_ms) + OFF_MS_W'(i_cfg_wdata[21:0]);
                end
                REG_DIM_LEVEL: begin
                    n_dim_level = i_cfg_wdata[6:0];
                end
                default: begin
                    n_dim_level = r_dim_level;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_ms  <= '0;
            r_off_ms    <= OFF_MS_W'(RESET_DIM_OFF_MS);
            r_wake_ms   <= {RESET_TICK_MS, 1'b0};
            r_dim_off   <= RESET_DIM_OFF_MS;
            r_dim_level <= RESET_DIM_LEVEL;
        end else begin
            r_sleep_ms  <= n_sleep_ms;
            r_off_ms    <= n_off_ms;
            r_wake_ms   <= n_wake_ms;
            r_dim_off   <= n_dim_off;
            r_dim_level <= n_dim_level;
        end
    end

    // classify the event against the touch-idle time
    always_comb begin
        o_cls.func        = i_event.func;
        o_cls.now_ms      = i_event.now_ms;
        o_cls.gated       = i_event.gated;
        o_cls.touch_wake  = i_event.touch_idle_ms < 32'(r_wake_ms);
        o_cls.touch_sleep = i_event.touch_idle_ms >= 32'(r_sleep_ms);
        o_cls.touch_off   = i_event.touch_idle_ms >= 32'(r_off_ms);
        o_cls.sleep_en    = r_sleep_ms != '0;
        o_cls.save_level  = (i_event.current_brightness < MIN_SAVED_LEVEL) ?
                            MIN_SAVED_LEVEL : i_event.current_brightness;
        o_cls.dim_level   = r_dim_level;
        o_cls.wake_ms     = r_wake_ms;
        o_cls.sleep_ms    = r_sleep_ms;
        o_cls.off_ms      = r_off_ms;
    end

endmodule

/* rtl/dido_queue.sv */
module dido_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dido_pkg::t_cls i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dido_pkg::t_cls o_data
);
    import dido_pkg::*;

    t_cls       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* rtl/dido_back.sv */
module dido_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  dido_pkg::t_cls    i_q_data,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output dido_pkg::t_result o_result
);
    import dido_pkg::*;

    typedef enum logic [1:0] {
        M_AWAKE = SLEEP_AWAKE,
        M_DIM   = SLEEP_DIM,
        M_OFF   = SLEEP_OFF
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [31:0] r_last_key, n_last_key;
    logic [31:0] r_anchor, n_anchor;
    logic [6:0]  r_saved, n_saved;
    logic        r_shield, n_shield;
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        fire;
    logic [31:0] d_key, d_anchor;
    logic        idle_wake, idle_sleep, idle_off;

    // take the next request when the result register is free or drains
    assign fire    = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = fire;
    assign o_empty = !r_out_valid;
    assign o_result = r_out;

    // idle is the least of three: compare each against the thresholds
    assign d_key     = i_q_data.now_ms - r_last_key;
    assign d_anchor  = i_q_data.now_ms - r_anchor;
    assign idle_wake = i_q_data.touch_wake ||
                       d_key < 32'(i_q_data.wake_ms) ||
                       d_anchor < 32'(i_q_data.wake_ms);
    assign idle_sleep = i_q_data.touch_sleep &&
                        d_key >= 32'(i_q_data.sleep_ms) &&
                        d_anchor >= 32'(i_q_data.sleep_ms);
    assign idle_off  = i_q_data.touch_off &&
                       d_key >= 32'(i_q_data.off_ms) &&
                       d_anchor >= 32'(i_q_data.off_ms);

    // state update and result for one event
    always_comb begin
        logic wake, hold_shield;
        n_mode      = r_mode;
        n_last_key  = r_last_key;
        n_anchor    = r_anchor;
        n_saved     = r_saved;
        n_shield    = r_shield;
        n_out       = '0;
        wake        = 1'b0;
        hold_shield = 1'b0;

        case (i_q_data.func)
            FUNC_TICK: begin
                if (i_q_data.gated) begin
                    n_anchor = i_q_data.now_ms;
                    wake     = 1'b1;
                end else if (r_mode != M_AWAKE) begin
                    if (idle_wake) begin
                        wake = 1'b1;
                    end else if (r_mode == M_DIM && i_q_data.sleep_en && idle_off) begin
                        n_out.brightness_write = 1'b1;
                        n_out.brightness_level = '0;
                        n_mode                 = M_OFF;
                        n_shield               = 1'b1;
                        n_out.off_notice       = NOTICE_ENTER;
                    end
                end else if (i_q_data.sleep_en && idle_sleep) begin
                    n_saved                = i_q_data.save_level;
                    n_out.brightness_write = 1'b1;
                    n_out.brightness_level = i_q_data.dim_level;
                    n_mode                 = M_DIM;
                    n_out.dim_notice       = NOTICE_ENTER;
                end
            end
            FUNC_KEY: begin
                n_last_key = i_q_data.now_ms;
                wake       = 1'b1;
                n_out.key_consumed = r_mode == M_OFF;
            end
            FUNC_SHIELD_PR: begin
                wake        = 1'b1;
                hold_shield = 1'b1;
            end
            default: begin
                n_shield = 1'b0;
            end
        endcase

        // wake from dim or off
        if (wake && r_mode != M_AWAKE) begin
            n_mode                 = M_AWAKE;
            n_anchor               = i_q_data.now_ms;
            n_out.brightness_write = 1'b1;
            n_out.brightness_level = r_saved;
            if (!hold_shield) begin
                n_shield = 1'b0;
            end
            if (r_mode == M_OFF) begin
                n_out.off_notice = NOTICE_LEAVE;
            end
            n_out.dim_notice = NOTICE_LEAVE;
        end

        n_out.sleep_state  = n_mode;
        n_out.shield_shown = n_shield;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_AWAKE;
            r_last_key  <= '0;
            r_anchor    <= '0;
            r_saved     <= RESET_BRIGHTNESS;
            r_shield    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_mode      <= n_mode;
                r_last_key  <= n_last_key;
                r_anchor    <= n_anchor;
                r_saved     <= n_saved;
                r_shield    <= n_shield;
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/display_idle_dim_off_controller.sv */
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------
// event in  | i_push / o_full       | i_event  (dido_pkg::t_event)
// result    | o_empty / i_pop       | o_result (dido_pkg::t_result)
// config    | i_cfg_we              | i_cfg_idx, i_cfg_wdata
//
// one event per cycle sustained while results are popped; an accepted event is
// registered in the queue, then in the result register (front classification into
// a two-entry queue, then the back stage that owns the sleep state and the result
// register). the state update in the back stage sets the rate.
// reset is synchronous, active low; clears state, queue and the result flag.
// a stalled result holds the back stage; the queue absorbs two more events.
module display_idle_dim_off_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dido_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dido_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_push,
    output logic                            o_full,
    input  dido_pkg::t_event                i_event,
    output logic                            o_empty,
    input  logic                            i_pop,
    output dido_pkg::t_result               o_result
);
    import dido_pkg::*;

    `include "display_idle_dim_off_controller_assert.svh"

    t_cls cls_in, cls_out;
    logic q_empty, q_pop;

    // classify incoming events and hold the thresholds
    dido_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_event     (i_event),
        .o_cls       (cls_in)
    );

    // decoupling queue
    dido_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls_in),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (cls_out)
    );

    // sleep state machine and result register
    dido_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (cls_out),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

    // a consumed key always reports a wake from off
    `DIDO_ASSERT_IMPLY(a_key_wake, i_clk, i_rst_n, !o_empty && o_result.key_consumed, o_result.off_notice == NOTICE_LEAVE && o_result.sleep_state == SLEEP_AWAKE, "consumed key without wake")
    // entering off blanks the backlight and shows the shield
    `DIDO_ASSERT_IMPLY(a_off_entry, i_clk, i_rst_n, !o_empty && o_result.off_notice == NOTICE_ENTER, o_result.sleep_state == SLEEP_OFF && o_result.shield_shown && o_result.brightness_write && o_result.brightness_level == 7'd0, "bad off entry")
    // entering dim writes a level
    `DIDO_ASSERT_IMPLY(a_dim_entry, i_clk, i_rst_n, !o_empty && o_result.dim_notice == NOTICE_ENTER, o_result.sleep_state == SLEEP_DIM && o_result.brightness_write, "bad dim entry")
    // a full queue means the back stage already holds a result
    `DIDO_ASSERT_NEXT(a_full_backs_up, i_clk, i_rst_n, o_full, !o_empty, "queue full with idle back stage")

endmodule
